FILE: rtl/dbcs_pkg.sv
package dbcs_pkg;

  localparam int unsigned TABLE_DEPTH = 131072;
  localparam int unsigned TABLE_AW    = 17;
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned DBCS_QDEPTH = 2;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;
  localparam logic [CFG_AW-1:0] REG_CONVERSION = 3'd0;

  localparam logic [1:0] CONV_BIG5_GBK = 2'd0;
  localparam logic [1:0] CONV_GBK_BIG5 = 2'd1;
  localparam logic [1:0] CONV_BIG5_UNI = 2'd2;
  localparam logic [1:0] CONV_GBK_UNI  = 2'd3;

  localparam logic MODE_TEXT  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  localparam logic [7:0] CHAR_QMARK = 8'h3F;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  localparam logic [1:0] CMD_EMIT   = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_WRITE  = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [7:0]  byte_in;
    logic [1:0]  table_select;
    logic [6:0]  table_row;
    logic [7:0]  table_col;
    logic [15:0] table_word;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       string_end;
    logic       last;
  } out_item_t;

  // One unit of work handed from the front to the back.
  typedef struct packed {
    logic [1:0]          kind;
    logic [TABLE_AW-1:0] addr;
    logic [WORD_W-1:0]   data;     // emit: {second byte, first byte}
    logic                two;      // two result bytes
    logic                fin_end;  // string_end on the final byte
  } cmd_t;

  function automatic logic is_unicode(input logic [1:0] conv);
    return (conv == CONV_BIG5_UNI) || (conv == CONV_GBK_UNI);
  endfunction

endpackage

FILE: rtl/dbcs_ram.sv
module dbcs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/dbcs_front.sv
module dbcs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        conversion,
  input  logic              in_valid,
  output logic              in_stall,
  input  dbcs_pkg::in_item_t in_data,
  input  logic              hold,
  input  logic              q_full,
  output logic              push,
  output dbcs_pkg::cmd_t    push_cmd
);

  import dbcs_pkg::*;

  logic       lead_pending_r, lead_pending_nxt;
  logic [6:0] lead_byte_r, lead_byte_nxt;
  logic       accept;
  logic       want_push;
  logic       uni;
  logic [7:0] b;

  assign in_stall = hold || q_full;
  assign accept   = in_valid && !in_stall;
  assign uni      = is_unicode(conversion);
  assign b        = in_data.byte_in;

  always_comb begin
    lead_pending_nxt = lead_pending_r;
    lead_byte_nxt    = lead_byte_r;
    want_push        = 1'b1;
    push_cmd.kind    = CMD_EMIT;
    push_cmd.addr    = {in_data.table_select, in_data.table_row, in_data.table_col};
    push_cmd.data    = in_data.table_word;
    push_cmd.two     = 1'b0;
    push_cmd.fin_end = 1'b0;
    if (in_data.mode == MODE_WRITE) begin
      push_cmd.kind = CMD_WRITE;
    end else if (lead_pending_r) begin
      lead_pending_nxt = 1'b0;
      push_cmd.two     = 1'b1;
      if (b == CHAR_NUL) begin
        push_cmd.data    = {CHAR_NUL, CHAR_QMARK};
        push_cmd.fin_end = 1'b1;
      end else begin
        push_cmd.kind = CMD_LOOKUP;
        push_cmd.addr = {conversion, lead_byte_r, b};
      end
    end else if (b == CHAR_NUL) begin
      push_cmd.data    = {CHAR_NUL, CHAR_NUL};
      push_cmd.two     = uni;
      push_cmd.fin_end = 1'b1;
    end else if (!b[7]) begin
      push_cmd.data = {CHAR_NUL, b};
      push_cmd.two  = uni;
    end else begin
      // lead byte: held until the next text byte
      want_push        = 1'b0;
      lead_pending_nxt = 1'b1;
      lead_byte_nxt    = b[6:0];
    end
  end

  assign push = accept && want_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_pending_r <= 1'b0;
      lead_byte_r    <= '0;
    end else if (accept) begin
      lead_pending_r <= lead_pending_nxt;
      lead_byte_r    <= lead_byte_nxt;
    end
  end

endmodule

FILE: rtl/dbcs_queue.sv
module dbcs_queue #(
  parameter int unsigned DEPTH = dbcs_pkg::DBCS_QDEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dbcs_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output dbcs_pkg::cmd_t q_cmd
);

  import dbcs_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_cmd   = slot_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: rtl/dbcs_back.sv
module dbcs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  dbcs_pkg::cmd_t     q_cmd,
  output logic               pop,
  output logic               clearing,
  output logic               out_valid,
  input  logic               out_stall,
  output dbcs_pkg::out_item_t out_data
);

  import dbcs_pkg::*;

  logic                clear_r;
  logic [TABLE_AW-1:0] clr_cnt_r;

  cmd_t      cur_r;
  logic      cur_valid_r, cur_valid_nxt;
  logic      cur_idx_r, cur_idx_nxt;
  logic      out_valid_r;
  out_item_t out_r;

  logic                out_free;
  logic                fire;
  logic                is_final;
  logic                cur_done;
  logic                pop_write;
  logic                ram_we;
  logic [TABLE_AW-1:0] ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [WORD_W-1:0]   ram_rdata;
  logic [WORD_W-1:0]   word;
  logic [7:0]          sel_byte;

  assign clearing  = clear_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign out_free = !out_valid_r || !out_stall;
  assign fire     = cur_valid_r && out_free;
  assign is_final = !cur_r.two || cur_idx_r;
  assign cur_done = fire && is_final;
  assign pop      = q_valid && !clear_r && (!cur_valid_r || cur_done);

  assign pop_write = pop && (q_cmd.kind == CMD_WRITE);
  assign ram_we    = clear_r || pop_write;
  assign ram_waddr = clear_r ? clr_cnt_r : q_cmd.addr;
  assign ram_wdata = clear_r ? '0 : q_cmd.data;
  assign ram_re    = pop && (q_cmd.kind == CMD_LOOKUP);

  dbcs_ram #(
    .WIDTH(WORD_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(q_cmd.addr),
    .rdata(ram_rdata)
  );

  // an unmapped entry reads as "??"
  always_comb begin
    if (cur_r.kind == CMD_LOOKUP) begin
      word = (ram_rdata == '0) ? {CHAR_QMARK, CHAR_QMARK} : ram_rdata;
    end else begin
      word = cur_r.data;
    end
    sel_byte = cur_idx_r ? word[15:8] : word[7:0];
  end

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_idx_nxt   = cur_idx_r;
    if (pop && !pop_write) begin
      cur_valid_nxt = 1'b1;
      cur_idx_nxt   = 1'b0;
    end else if (cur_done) begin
      cur_valid_nxt = 1'b0;
    end else if (fire) begin
      cur_idx_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !pop_write) begin
      cur_r <= q_cmd;
    end
    if (fire) begin
      out_r.out_byte   <= sel_byte;
      out_r.string_end <= is_final && cur_r.fin_end;
      out_r.last       <= is_final;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_r     <= 1'b1;
      clr_cnt_r   <= '0;
      cur_valid_r <= 1'b0;
      cur_idx_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clear_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          clear_r <= 1'b0;
        end
      end
      cur_valid_r <= cur_valid_nxt;
      cur_idx_r   <= cur_idx_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/dbcs_table_transcoder.sv
// Big5/GBK/UTF-16LE byte-stream transcoder. Text bytes enter on the in_
// channel, converted bytes leave on the out_ channel one per cycle while
// out_stall is low, and table-write items load the four 128x256 code
// tables in a simple dual-port RAM. After reset the block sweeps the whole
// table memory to zero, one word a cycle: in_stall stays high while the
// sweep runs (the conversion register can be written meanwhile). After
// that, each text item yields its one or two result bytes one at a time on
// the result port, and table writes and lead bytes yield none. A small
// command queue sits between the input side and the table/output side, so
// input keeps flowing while results wait on out_stall, until the queue
// fills.
module dbcs_table_transcoder #(
  parameter int unsigned QUEUE_DEPTH = dbcs_pkg::DBCS_QDEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  dbcs_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output dbcs_pkg::out_item_t         out_data,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [dbcs_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [dbcs_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [dbcs_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  import dbcs_pkg::*;

  logic [1:0] conversion_r;
  logic       q_full;
  logic       push;
  cmd_t       push_cmd;
  logic       pop;
  logic       q_valid;
  cmd_t       q_cmd;
  logic       clearing;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_CONVERSION) ?
                      {{(CFG_DW - 2){1'b0}}, conversion_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conversion_r <= CONV_BIG5_GBK;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == REG_CONVERSION) begin
      conversion_r <= cfg_pwdata[1:0];
    end
  end

  dbcs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .conversion(conversion_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .hold      (clearing),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  dbcs_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .q_cmd   (q_cmd)
  );

  dbcs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop),
    .clearing (clearing),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
